/* rtl/pds_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, control types and state codes for the proper divisor sum block.
// No dependencies; used by pds_div and proper_divisor_sum.
package pds_pkg;

    localparam int NUM_W       = 31;                     // width of the analysed number
    localparam int DIV_W       = (NUM_W + 2) / 2;        // trial divisor, up to sqrt + 1
    localparam int CNT_W       = 11;                     // divisor count
    localparam int SUM_W       = 34;                     // proper-divisor sum
    localparam int BIT_W       = $clog2(NUM_W);          // divider step counter
    localparam int IN_TDATA_W  = ((NUM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CNT_W + SUM_W + 7) / 8) * 8;
    localparam int CMP_W       = 64;                     // width for the perfect-number compare

    // Divider status toward the sequencer.
    typedef struct packed {
        logic done;      // one-cycle pulse: quotient and remainder are final
        logic rem_zero;  // remainder is zero
    } t_div_stat;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_COF  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

endpackage

/* rtl/pds_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, NUM_W quotient bits in all.
// Depends on pds_pkg for widths and the status struct.
module pds_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pds_pkg::NUM_W-1:0]  i_dividend,
    input  logic [pds_pkg::DIV_W-1:0]  i_divisor,   // held stable while busy
    output pds_pkg::t_div_stat         o_stat,
    output logic [pds_pkg::NUM_W-1:0]  o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [pds_pkg::BIT_W-1:0]  r_bit;
    logic [pds_pkg::DIV_W-1:0]  r_rem;
    logic [pds_pkg::NUM_W-1:0]  r_quo;   // dividend bits shift out, quotient bits shift in

    logic [pds_pkg::DIV_W:0]    w_trial;
    logic [pds_pkg::DIV_W:0]    w_diff;
    logic                       w_fits;
    logic [pds_pkg::DIV_W-1:0]  n_rem;

    // Remainder stays below the divisor, so the trial value stays below twice it.
    assign w_trial = {r_rem, r_quo[pds_pkg::NUM_W-1]};
    assign w_fits  = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign n_rem   = w_fits ? w_diff[pds_pkg::DIV_W-1:0] : w_trial[pds_pkg::DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= pds_pkg::BIT_W'(pds_pkg::NUM_W - 1);
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - pds_pkg::BIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[pds_pkg::NUM_W-2:0], w_fits};
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_quotient      = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < i_divisor))
        else $error("divider remainder reached the divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished pass");

    a_start_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted during a pass");

endmodule

/* rtl/proper_divisor_sum.sv */
`timescale 1ns / 1ps
// Top level: aliquot sum by trial division, driving the bit-serial divider.
// Depends on pds_pkg and pds_div.
//
// Usage:
//   Input channel s_axis_*: one item carries the number to analyse in the low
//   NUM_W bits of s_axis_tdata; upper bits are ignored. An item is taken only
//   while the block is idle (s_axis_tready high).
//   Output channel m_axis_*: one item per input item with the divisor count,
//   the proper-divisor sum and, in m_axis_tuser, the perfect-number flag.
//   Each trial divisor d = 1, 2, ... runs one pass of the serial divider,
//   then an evaluate step; when d divides n and its cofactor n / d must be
//   added too, a cofactor step follows before the next pass. The loop ends
//   once d * d exceeds n, so most of the time goes into the divider passes.
//   Numbers below two skip the divider and go straight to the result.
//   One item is processed at a time; the next input item is taken as soon
//   as its result has moved into the output register.
//   The output register holds a result until m_axis_tready takes it; while it
//   is full, a finished result waits in the sequencer and no new item enters.
//   Reset (i_rst_n low, synchronous) returns to idle and drops any result.
module proper_divisor_sum (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pds_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [30:0] number
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [10:0] divisor_count,
                                                             // [44:11] divisor_sum
    output logic                             m_axis_tuser    // [0] is_perfect
);

    pds_pkg::t_state                 r_state;
    logic [pds_pkg::NUM_W-1:0]       r_num;
    logic [pds_pkg::DIV_W-1:0]       r_d;
    logic [pds_pkg::CNT_W-1:0]       r_count;
    logic [pds_pkg::SUM_W-1:0]       r_sum;
    logic                            r_out_valid;
    logic [pds_pkg::CNT_W-1:0]       r_out_count;
    logic [pds_pkg::SUM_W-1:0]       r_out_sum;
    logic                            r_out_perf;

    logic                            w_in_take;
    logic [pds_pkg::NUM_W-1:0]       w_in_num;
    logic                            w_start;
    logic [pds_pkg::NUM_W-1:0]       w_dividend;
    pds_pkg::t_div_stat              w_stat;
    logic [pds_pkg::NUM_W-1:0]       w_quo;
    logic                            w_stop;
    logic                            w_cof;
    logic                            w_out_load;
    logic                            w_perfect;

    assign s_axis_tready = (r_state == pds_pkg::ST_IDLE);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign w_in_num      = s_axis_tdata[pds_pkg::NUM_W-1:0];

    // Loop ends once d exceeds n / d, which is d * d > n.
    assign w_stop = pds_pkg::NUM_W'(r_d) > w_quo;
    // Cofactor counts too, unless d is one or the exact square root.
    assign w_cof  = w_stat.rem_zero && (r_d != pds_pkg::DIV_W'(1))
                    && (w_quo != pds_pkg::NUM_W'(r_d));

    // Kick the divider on a fresh number of two or more, or on the next divisor.
    always_comb begin
        w_start = 1'b0;
        unique case (r_state)
            pds_pkg::ST_IDLE: w_start = w_in_take && (w_in_num > pds_pkg::NUM_W'(1));
            pds_pkg::ST_EVAL: w_start = !w_stop && !w_cof;
            pds_pkg::ST_COF:  w_start = 1'b1;
            pds_pkg::ST_DIV,
            pds_pkg::ST_DONE: w_start = 1'b0;
            default:          w_start = 1'b0;
        endcase
    end

    assign w_dividend = (r_state == pds_pkg::ST_IDLE) ? w_in_num : r_num;

    pds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_d),
        .o_stat     (w_stat),
        .o_quotient (w_quo)
    );

    assign w_out_load = (r_state == pds_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);
    assign w_perfect  = (r_num != '0)
                        && (pds_pkg::CMP_W'(r_sum) == pds_pkg::CMP_W'(r_num));

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pds_pkg::ST_IDLE;
        end else begin
            unique case (r_state)
                pds_pkg::ST_IDLE: begin
                    if (w_in_take) begin
                        r_state <= w_start ? pds_pkg::ST_DIV : pds_pkg::ST_DONE;
                    end
                end
                pds_pkg::ST_DIV: begin
                    if (w_stat.done) begin
                        r_state <= pds_pkg::ST_EVAL;
                    end
                end
                pds_pkg::ST_EVAL: begin
                    priority if (w_stop) begin
                        r_state <= pds_pkg::ST_DONE;
                    end else if (w_cof) begin
                        r_state <= pds_pkg::ST_COF;
                    end else begin
                        r_state <= pds_pkg::ST_DIV;
                    end
                end
                pds_pkg::ST_COF: begin
                    r_state <= pds_pkg::ST_DIV;
                end
                pds_pkg::ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= pds_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= pds_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Working registers: number, trial divisor, running count and sum.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_num   <= w_in_num;
            r_d     <= pds_pkg::DIV_W'(1);
            r_count <= '0;
            r_sum   <= '0;
        end else if (r_state == pds_pkg::ST_EVAL) begin
            if (!w_stop && w_stat.rem_zero) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + pds_pkg::SUM_W'(r_d);
            end
            // Advance to the next divisor unless the loop ends or the cofactor still needs adding.
            if (!w_stop && !w_cof) begin
                r_d <= r_d + 1'b1;
            end
        end else if (r_state == pds_pkg::ST_COF) begin
            r_count <= r_count + 1'b1;
            r_sum   <= r_sum + pds_pkg::SUM_W'(w_quo);
            r_d     <= r_d + 1'b1;
        end
    end

    // Output register: hold until the receiver takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= r_count;
            r_out_sum   <= r_sum;
            r_out_perf  <= w_perfect;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pds_pkg::OUT_TDATA_W'({r_out_sum, r_out_count});
    assign m_axis_tuser  = r_out_perf;

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pds_pkg::ST_DIV) |-> (r_d != '0))
        else $error("trial divisor is zero during a divide");

    a_cofactor_needs_d_above_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pds_pkg::ST_COF) |-> (r_d > pds_pkg::DIV_W'(1)))
        else $error("cofactor step for divisor one");

    a_done_from_eval_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pds_pkg::ST_EVAL) && w_stop |=> (r_state == pds_pkg::ST_DONE))
        else $error("loop did not finish when the divisor passed the square root");

    a_start_only_when_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == pds_pkg::ST_DIV))
        else $error("divider started outside a divide pass");

endmodule
